[rtl/cpsp_pkg.sv]
// ============================================================================
// cpsp_pkg
// shared widths, codes and constants of the cascaded position/speed pid
// ============================================================================
package cpsp_pkg;

    localparam int KIND_W        = 2;
    localparam int SMP_W         = 32;
    localparam int GAIN_W        = 24;
    localparam int SUM_W         = 48;
    localparam int ERR_W         = 33;
    localparam int ANG_W         = 34;
    localparam int ACC_W         = 72;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DEC_K         = 1000;

    // pi with 32 fractional bits
    localparam longint PI_Q32 = 64'd13493037705;

    localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPEED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PKP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PKI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PKD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SKD  = 3'd6;

    localparam logic signed [SMP_W-1:0] GOAL_RST = 32'sd102944;
    localparam logic [GAIN_W-1:0] PKP_RST = 24'd98304;
    localparam logic [GAIN_W-1:0] PKI_RST = 24'd0;
    localparam logic [GAIN_W-1:0] PKD_RST = 24'd0;
    localparam logic [GAIN_W-1:0] SKP_RST = 24'd262144;
    localparam logic [GAIN_W-1:0] SKI_RST = 24'd13107;
    localparam logic [GAIN_W-1:0] SKD_RST = 24'd3277;

    // pi rounded to f fractional bits
    function automatic longint pi_q(input int f);
        return (PI_Q32 + (longint'(1) << (31 - f))) >>> (32 - f);
    endfunction

endpackage

[rtl/cpsp_if.sv]
// ============================================================================
// cpsp_if
// valid/ready channels for input items and result items
// ============================================================================
interface cpsp_in_if import cpsp_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [SMP_W-1:0] sample;

    modport source (output valid, kind, sample, input ready);
    modport sink   (input valid, kind, sample, output ready);
endinterface

interface cpsp_out_if import cpsp_pkg::*; #(
    parameter int TQ_W = FRAC_BITS_DEF + 4,
    parameter int SG_W = FRAC_BITS_DEF + 3
);
    logic                    valid;
    logic                    ready;
    logic signed [TQ_W-1:0]  torque;
    logic signed [SG_W-1:0]  speed_goal;
    logic signed [SMP_W-1:0] arc_goal;

    modport source (output valid, torque, speed_goal, arc_goal, input ready);
    modport sink   (input valid, torque, speed_goal, arc_goal, output ready);
endinterface

[rtl/cpsp_mul.sv]
// ============================================================================
// cpsp_mul
// bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
// ============================================================================
module cpsp_mul import cpsp_pkg::*; #(
    parameter int A_W = ACC_W,
    parameter int B_W = GAIN_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [A_W-1:0] a,
    input  logic [B_W-1:0]        b,
    output logic                  busy,
    output logic signed [A_W-1:0] prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [A_W-1:0] acc_reg, acc_next;
    logic signed [A_W-1:0] mcand_reg, mcand_next;
    logic [B_W-1:0]        mplier_reg, mplier_next;

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

    always_comb
    begin
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            cnt_next    = CNT_W'(B_W);
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
        end
        else if (busy)
        begin
            // one multiplier bit per cycle
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

[rtl/cpsp_div.sv]
// ============================================================================
// cpsp_div
// bit-serial restoring divider, floor quotient and remainder of a signed value
// ============================================================================
module cpsp_div import cpsp_pkg::*; #(
    parameter int X_W = SUM_W,
    parameter int D_W = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [X_W-1:0] x,
    input  logic [D_W-1:0]        d,
    output logic                  busy,
    output logic signed [X_W-1:0] quo,
    output logic [D_W-1:0]        rem
);

    localparam int CNT_W = $clog2(X_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [X_W-1:0]   dvd_reg, dvd_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W:0]     trial;
    logic             fits;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, dvd_reg[X_W-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    // a negative value is divided as its complement and mapped back
    assign quo = neg_reg ? $signed(~dvd_reg) : $signed(dvd_reg);
    assign rem = neg_reg ? (d_reg - D_W'(1) - rem_reg) : rem_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        d_next   = d_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(X_W);
            neg_next = x[X_W-1];
            d_next   = d;
            dvd_next = x[X_W-1] ? ~x : x;
            rem_next = '0;
        end
        else if (busy)
        begin
            rem_next = fits ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
            dvd_next = {dvd_reg[X_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        d_reg   <= d_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

endmodule

[rtl/cascaded_position_speed_pid.sv]
// ============================================================================
// cascaded_position_speed_pid
// cascaded position and speed pid with long-arc target, bit-serial datapath
// ============================================================================
// Items carry an angle sample, a speed sample or a control tick. A speed
// sample, a later angle sample or an early tick is taken in the idle state
// without leaving it. The first angle sample fixes the long-arc target
// through three floor-mod passes of the bit-serial divider. A tick runs the
// position loop and then the speed loop; each loop issues four passes of the
// bit-serial multiplier (p term, d gain, times 1000, i term) at one gain bit
// per cycle, so the multiplier sets the length of a tick. The divider for the
// integral runs beside the multiplier and adds nothing. A result waits in
// an output register while the next item is accepted.
// ============================================================================
module cascaded_position_speed_pid import cpsp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    cpsp_in_if.sink              in_ch,
    cpsp_out_if.source           out_ch
);

    localparam int     TQ_W     = FRAC_BITS + 4;
    localparam int     SG_W     = FRAC_BITS + 3;
    localparam int     TOT_W    = ACC_W + 2;
    localparam longint PI_L     = pi_q(FRAC_BITS);
    localparam longint TWO_PI_L = 2 * PI_L;
    localparam int     DVS_W    = $clog2(TWO_PI_L + 1);

    localparam logic signed [ANG_W-1:0] PI_A     = ANG_W'(PI_L);
    localparam logic signed [ANG_W-1:0] TWO_PI_A = ANG_W'(TWO_PI_L);
    localparam logic [DVS_W-1:0]        TWO_PI_D = DVS_W'(TWO_PI_L);
    localparam logic [DVS_W-1:0]        DEC_D    = DVS_W'(DEC_K);
    localparam logic signed [TOT_W-1:0] LIM_SG   = TOT_W'(longint'(2) << FRAC_BITS);
    localparam logic signed [TOT_W-1:0] LIM_TQ   = TOT_W'(longint'(5) << FRAC_BITS);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;  // takes items
    localparam logic [3:0] ST_WG   = 4'd1;  // wrapping goal angle
    localparam logic [3:0] ST_WA   = 4'd2;  // wrapping current angle
    localparam logic [3:0] ST_WS   = 4'd3;  // wrapping short difference
    localparam logic [3:0] ST_ERR  = 4'd4;  // loop error and integrator
    localparam logic [3:0] ST_P    = 4'd5;  // p product
    localparam logic [3:0] ST_D1   = 4'd6;  // kd times error step
    localparam logic [3:0] ST_D2   = 4'd7;  // times 1000
    localparam logic [3:0] ST_I    = 4'd8;  // i product, sum and clamp

    logic [3:0] state_reg, state_next;

    // configuration
    logic signed [SMP_W-1:0] goal_reg, goal_next;
    logic [GAIN_W-1:0] pkp_reg, pkp_next, pki_reg, pki_next, pkd_reg, pkd_next;
    logic [GAIN_W-1:0] skp_reg, skp_next, ski_reg, ski_next, skd_reg, skd_next;

    // controller state
    logic signed [SMP_W-1:0] last_angle_reg, last_angle_next;
    logic signed [SMP_W-1:0] last_speed_reg, last_speed_next;
    logic signed [SMP_W-1:0] arc_reg, arc_next;
    logic                    ready_reg, ready_next;
    logic signed [SUM_W-1:0] psum_reg, psum_next, ssum_reg, ssum_next;
    logic signed [ERR_W-1:0] pprev_reg, pprev_next, sprev_reg, sprev_next;

    // working registers
    logic                    loop_reg, loop_next;   // 0 position, 1 speed
    logic signed [ERR_W-1:0] e_reg, e_next;
    logic signed [ACC_W-1:0] pterm_reg, pterm_next, dterm_reg, dterm_next;
    logic signed [SG_W-1:0]  sg_reg, sg_next;
    logic signed [ANG_W-1:0] w1_reg, w1_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [TQ_W-1:0]  tq_out_reg, tq_out_next;
    logic signed [SG_W-1:0]  sg_out_reg, sg_out_next;
    logic signed [SMP_W-1:0] arc_out_reg, arc_out_next;

    // serial units
    logic                    mul_go, mul_busy;
    logic signed [ACC_W-1:0] mul_a, mul_prod;
    logic [GAIN_W-1:0]       mul_b;
    logic                    div_go, div_busy;
    logic signed [SUM_W-1:0] div_x, div_quo;
    logic [DVS_W-1:0]        div_d, div_rem;

    // datapath terms
    logic                    accept;
    logic signed [ERR_W-1:0] e_new;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic [GAIN_W-1:0]       kp_sel, ki_sel, kd_sel;
    logic signed [ERR_W:0]   diff;
    logic signed [ACC_W-1:0] i_term;
    logic signed [TOT_W-1:0] total, lim, clamped;
    logic signed [ANG_W-1:0] rem_w, lng, tgt, ang_x;

    cpsp_mul #(
        .A_W (ACC_W),
        .B_W (GAIN_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    cpsp_div #(
        .X_W (SUM_W),
        .D_W (DVS_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .x     (div_x),
        .d     (div_d),
        .busy  (div_busy),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign accept            = in_ch.valid && in_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.torque     = tq_out_reg;
    assign out_ch.speed_goal = sg_out_reg;
    assign out_ch.arc_goal   = arc_out_reg;

    // loop error: position error, or speed goal minus measured speed
    assign e_new = loop_reg
        ? ({{(ERR_W-SG_W){sg_reg[SG_W-1]}}, sg_reg}
           - {last_speed_reg[SMP_W-1], last_speed_reg})
        : ({arc_reg[SMP_W-1], arc_reg} - {last_angle_reg[SMP_W-1], last_angle_reg});

    // saturating integrator update
    assign sum_wide = loop_reg
        ? ({ssum_reg[SUM_W-1], ssum_reg} + {{(SUM_W+1-ERR_W){e_new[ERR_W-1]}}, e_new})
        : ({psum_reg[SUM_W-1], psum_reg} + {{(SUM_W+1-ERR_W){e_new[ERR_W-1]}}, e_new});
    assign sum_sat = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        ? (sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
        : sum_wide[SUM_W-1:0];

    assign kp_sel = loop_reg ? skp_reg : pkp_reg;
    assign ki_sel = loop_reg ? ski_reg : pki_reg;
    assign kd_sel = loop_reg ? skd_reg : pkd_reg;
    assign diff   = loop_reg
        ? ({e_reg[ERR_W-1], e_reg} - {sprev_reg[ERR_W-1], sprev_reg})
        : ({e_reg[ERR_W-1], e_reg} - {pprev_reg[ERR_W-1], pprev_reg});

    // floor shifts of the products, sum and clamp
    assign i_term  = mul_prod >>> FRAC_BITS;
    assign total   = {{2{pterm_reg[ACC_W-1]}}, pterm_reg}
                   + {{2{dterm_reg[ACC_W-1]}}, dterm_reg}
                   + {{2{i_term[ACC_W-1]}}, i_term};
    assign lim     = loop_reg ? LIM_TQ : LIM_SG;
    assign clamped = (total > lim) ? lim : ((total < -lim) ? -lim : total);

    // wrapped value from the floor remainder, long arc and target
    assign rem_w = $signed(ANG_W'(div_rem)) - PI_A;
    assign lng   = (rem_w > 0) ? (rem_w - TWO_PI_A) : (rem_w + TWO_PI_A);
    assign tgt   = {{(ANG_W-SMP_W){last_angle_reg[SMP_W-1]}}, last_angle_reg} + lng;
    assign ang_x = w1_reg - rem_w + PI_A;

    always_comb
    begin
        state_next      = state_reg;
        goal_next       = goal_reg;
        pkp_next        = pkp_reg;
        pki_next        = pki_reg;
        pkd_next        = pkd_reg;
        skp_next        = skp_reg;
        ski_next        = ski_reg;
        skd_next        = skd_reg;
        last_angle_next = last_angle_reg;
        last_speed_next = last_speed_reg;
        arc_next        = arc_reg;
        ready_next      = ready_reg;
        psum_next       = psum_reg;
        ssum_next       = ssum_reg;
        pprev_next      = pprev_reg;
        sprev_next      = sprev_reg;
        loop_next       = loop_reg;
        e_next          = e_reg;
        pterm_next      = pterm_reg;
        dterm_next      = dterm_reg;
        sg_next         = sg_reg;
        w1_next         = w1_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        tq_out_next     = tq_out_reg;
        sg_out_next     = sg_out_reg;
        arc_out_next    = arc_out_reg;
        mul_go          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_go          = 1'b0;
        div_x           = '0;
        div_d           = TWO_PI_D;

        if (cfg_we)
        begin
            case (cfg_idx)
                REG_GOAL: goal_next = $signed(cfg_data[SMP_W-1:0]);
                REG_PKP:  pkp_next  = cfg_data[GAIN_W-1:0];
                REG_PKI:  pki_next  = cfg_data[GAIN_W-1:0];
                REG_PKD:  pkd_next  = cfg_data[GAIN_W-1:0];
                REG_SKP:  skp_next  = cfg_data[GAIN_W-1:0];
                REG_SKI:  ski_next  = cfg_data[GAIN_W-1:0];
                REG_SKD:  skd_next  = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.kind)
                        KIND_ANGLE:
                        begin
                            last_angle_next = in_ch.sample;
                            if (!ready_reg)
                            begin
                                // goal plus pi, floor mod two pi
                                div_go     = 1'b1;
                                div_x      = {{(SUM_W-SMP_W){goal_reg[SMP_W-1]}}, goal_reg}
                                           + SUM_W'(PI_L);
                                state_next = ST_WG;
                            end
                        end
                        KIND_SPEED:
                        begin
                            last_speed_next = in_ch.sample;
                        end
                        KIND_TICK:
                        begin
                            // ticks before the target is fixed do nothing
                            if (ready_reg)
                            begin
                                loop_next  = 1'b0;
                                state_next = ST_ERR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WG:
            begin
                if (!div_busy)
                begin
                    w1_next    = rem_w;
                    div_go     = 1'b1;
                    div_x      = {{(SUM_W-SMP_W){last_angle_reg[SMP_W-1]}}, last_angle_reg}
                               + SUM_W'(PI_L);
                    state_next = ST_WA;
                end
            end
            ST_WA:
            begin
                if (!div_busy)
                begin
                    div_go     = 1'b1;
                    div_x      = {{(SUM_W-ANG_W){ang_x[ANG_W-1]}}, ang_x};
                    state_next = ST_WS;
                end
            end
            ST_WS:
            begin
                if (!div_busy)
                begin
                    // saturate the target to the angle range
                    if (!(&tgt[ANG_W-1:SMP_W-1]) && (|tgt[ANG_W-1:SMP_W-1]))
                    begin
                        arc_next = tgt[ANG_W-1] ? {1'b1, {(SMP_W-1){1'b0}}}
                                                : {1'b0, {(SMP_W-1){1'b1}}};
                    end
                    else
                    begin
                        arc_next = tgt[SMP_W-1:0];
                    end
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                e_next = e_new;
                if (loop_reg)
                begin
                    ssum_next = sum_sat;
                end
                else
                begin
                    psum_next = sum_sat;
                end
                // p product and the integral divide run side by side
                mul_go     = 1'b1;
                mul_a      = {{(ACC_W-ERR_W){e_new[ERR_W-1]}}, e_new};
                mul_b      = kp_sel;
                div_go     = 1'b1;
                div_x      = sum_sat;
                div_d      = DEC_D;
                state_next = ST_P;
            end
            ST_P:
            begin
                if (!mul_busy)
                begin
                    pterm_next = mul_prod >>> FRAC_BITS;
                    mul_go     = 1'b1;
                    mul_a      = {{(ACC_W-ERR_W-1){diff[ERR_W]}}, diff};
                    mul_b      = kd_sel;
                    state_next = ST_D1;
                end
            end
            ST_D1:
            begin
                if (!mul_busy)
                begin
                    mul_go     = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = GAIN_W'(DEC_K);
                    state_next = ST_D2;
                end
            end
            ST_D2:
            begin
                if (!mul_busy && !div_busy)
                begin
                    dterm_next = mul_prod >>> FRAC_BITS;
                    mul_go     = 1'b1;
                    mul_a      = {{(ACC_W-SUM_W){div_quo[SUM_W-1]}}, div_quo};
                    mul_b      = ki_sel;
                    state_next = ST_I;
                end
            end
            ST_I:
            begin
                if (!mul_busy)
                begin
                    if (!loop_reg)
                    begin
                        // position loop done, its output drives the speed loop
                        sg_next    = clamped[SG_W-1:0];
                        pprev_next = e_reg;
                        loop_next  = 1'b1;
                        state_next = ST_ERR;
                    end
                    else if (!out_valid_reg || out_ch.ready)
                    begin
                        sprev_next     = e_reg;
                        tq_out_next    = clamped[TQ_W-1:0];
                        sg_out_next    = sg_reg;
                        arc_out_next   = arc_reg;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            goal_reg       <= GOAL_RST;
            pkp_reg        <= PKP_RST;
            pki_reg        <= PKI_RST;
            pkd_reg        <= PKD_RST;
            skp_reg        <= SKP_RST;
            ski_reg        <= SKI_RST;
            skd_reg        <= SKD_RST;
            last_angle_reg <= '0;
            last_speed_reg <= '0;
            arc_reg        <= '0;
            ready_reg      <= 1'b0;
            psum_reg       <= '0;
            ssum_reg       <= '0;
            pprev_reg      <= '0;
            sprev_reg      <= '0;
            loop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            goal_reg       <= goal_next;
            pkp_reg        <= pkp_next;
            pki_reg        <= pki_next;
            pkd_reg        <= pkd_next;
            skp_reg        <= skp_next;
            ski_reg        <= ski_next;
            skd_reg        <= skd_next;
            last_angle_reg <= last_angle_next;
            last_speed_reg <= last_speed_next;
            arc_reg        <= arc_next;
            ready_reg      <= ready_next;
            psum_reg       <= psum_next;
            ssum_reg       <= ssum_next;
            pprev_reg      <= pprev_next;
            sprev_reg      <= sprev_next;
            loop_reg       <= loop_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        pterm_reg   <= pterm_next;
        dterm_reg   <= dterm_next;
        sg_reg      <= sg_next;
        w1_reg      <= w1_next;
        tq_out_reg  <= tq_out_next;
        sg_out_reg  <= sg_out_next;
        arc_out_reg <= arc_out_next;
    end

`ifndef SYNTH
    // both serial units are free whenever items are taken
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (!mul_busy && !div_busy))
        else $error("serial unit busy while taking items");

    // a result appears only when the speed loop finishes
    a_out_from_loop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_I && $past(loop_reg)))
        else $error("result raised outside speed loop completion");

    // once fixed, the target stays fixed
    a_target_kept: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |=> (ready_reg && $stable(arc_reg)))
        else $error("target changed after it was fixed");

    // loop computation only runs with a fixed target
    a_loop_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERR) |-> ready_reg)
        else $error("loop running without a target");
`endif

endmodule
